// ===== rtl/smd_pkg.sv =====
// shared types and constants for the stereo multimode delay
`timescale 1ns / 1ps
`default_nettype none
package smd_pkg;

  localparam int unsigned LINE_AW_DEF         = 11;
  localparam int unsigned SAMPLE_BITS_DEF     = 24;
  localparam int unsigned GAIN_FRAC_BITS_DEF  = 14;
  localparam int unsigned FB_FRAC_BITS        = 14;
  localparam int unsigned DELAY_W             = 11;
  localparam int unsigned FB_GAIN_W           = 15;
  localparam int unsigned MIX_GAIN_W          = 16;
  localparam int unsigned CFG_ADDR_W          = 3;
  localparam int unsigned CFG_DATA_W          = 16;
  localparam logic [MIX_GAIN_W-1:0] MIX_GAIN_RST = 16'd11599;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_PING_PONG,
    MODE_LCR,
    MODE_TAP
  } mode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MODE,
    REG_DELAY_LEFT,
    REG_DELAY_CENTRE,
    REG_DELAY_RIGHT,
    REG_FEEDBACK_GAIN,
    REG_DRY_GAIN,
    REG_WET_GAIN
  } reg_idx_t;

  typedef enum logic [1:0] {
    TAP_3Q,
    TAP_HALF,
    TAP_1Q
  } tap_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_WRITE,
    S_TAP0,
    S_TAP1,
    S_TAP2,
    S_TAPEND,
    S_FIN
  } state_t;

  typedef struct packed {
    mode_t                 mode;
    logic [DELAY_W-1:0]    delay_left;
    logic [DELAY_W-1:0]    delay_centre;
    logic [DELAY_W-1:0]    delay_right;
    logic [FB_GAIN_W-1:0]  feedback_gain;
    logic [MIX_GAIN_W-1:0] dry_gain;
    logic [MIX_GAIN_W-1:0] wet_gain;
  } smd_cfg_t;

  typedef struct packed {
    logic clearing;
    logic start;
    logic mul_en;
    logic wr_en;
    logic tap_rd;
    tap_t tap_sel;
    logic tap_acc;
    logic out_load;
  } smd_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/smd_line_ram.sv =====
// one delay line: simple dual port memory, registered read
`timescale 1ns / 1ps
`default_nettype none
module smd_line_ram #(
  parameter int unsigned AW = smd_pkg::LINE_AW_DEF,
  parameter int unsigned DW = smd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/smd_datapath.sv =====
// multiply, feedback, line write data, mix and tap accumulation
`timescale 1ns / 1ps
`default_nettype none
module smd_datapath #(
  parameter int unsigned SAMPLE_BITS    = smd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = smd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire smd_pkg::smd_cfg_t             cfg,
  input  wire smd_pkg::smd_ctl_t             ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] x_l,
  input  wire logic signed [SAMPLE_BITS-1:0] x_r,
  input  wire logic                          stereo,
  input  wire logic signed [SAMPLE_BITS-1:0] y_l,
  input  wire logic signed [SAMPLE_BITS-1:0] y_c,
  input  wire logic signed [SAMPLE_BITS-1:0] y_r,
  output logic        [SAMPLE_BITS-1:0]      wdata_l,
  output logic        [SAMPLE_BITS-1:0]      wdata_c,
  output logic        [SAMPLE_BITS-1:0]      wdata_r,
  output logic        [SAMPLE_BITS-1:0]      res_l,
  output logic        [SAMPLE_BITS-1:0]      res_r
);
  import smd_pkg::*;

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned PFW = SB + FB_GAIN_W + 1;
  localparam int unsigned PMW = SB + MIX_GAIN_W + 1;
  localparam int unsigned ACW = SB + MIX_GAIN_W + 4;
  localparam int unsigned TW  = SB + 2;
  localparam logic signed [ACW-1:0] FB_HALF  = ACW'(2**(FB_FRAC_BITS - 1));
  localparam logic signed [ACW-1:0] MIX_HALF = ACW'(2**(GAIN_FRAC_BITS - 1));
  localparam logic signed [ACW-1:0] S_MAX = {{(ACW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [ACW-1:0] S_MIN = {{(ACW-SB+1){1'b1}}, {(SB-1){1'b0}}};

  function automatic logic [SB-1:0] sat(input logic signed [ACW-1:0] v);
    logic [ACW-1:0] r;
    if (v > S_MAX) begin
      r = S_MAX;
    end else if (v < S_MIN) begin
      r = S_MIN;
    end else begin
      r = v;
    end
    return r[SB-1:0];
  endfunction

  logic signed [FB_GAIN_W:0]  fb_s;
  logic signed [MIX_GAIN_W:0] dry_s;
  logic signed [MIX_GAIN_W:0] wet_s;

  logic signed [PFW-1:0] pf_l_r, pf_c_r, pf_r_r;
  logic signed [PMW-1:0] pd_l_r, pd_r_r, pw_l_r, pw_r_r, pw_c_r;
  logic signed [ACW-1:0] acc_l_r, acc_r_r;
  logic signed [TW-1:0]  tap_l_r, tap_r_r;

  logic signed [ACW-1:0] fbt_l, fbt_c, fbt_r;
  logic        [SB-1:0]  feed_l, feed_r, centre;
  logic signed [PMW-1:0] pw_c_sel;
  logic                  lcr_mix;
  logic signed [ACW-1:0] sum_l, sum_r;

  assign fb_s  = $signed({1'b0, cfg.feedback_gain});
  assign dry_s = $signed({1'b0, cfg.dry_gain});
  assign wet_s = $signed({1'b0, cfg.wet_gain});

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      pf_l_r <= fb_s * y_l;
      pf_c_r <= fb_s * y_c;
      pf_r_r <= fb_s * y_r;
      pd_l_r <= dry_s * x_l;
      pd_r_r <= dry_s * x_r;
      pw_l_r <= wet_s * y_l;
      pw_r_r <= wet_s * y_r;
      pw_c_r <= wet_s * y_c;
    end
  end

  always_comb begin
    fbt_l    = (ACW'(pf_l_r) + FB_HALF) >>> FB_FRAC_BITS;
    fbt_c    = (ACW'(pf_c_r) + FB_HALF) >>> FB_FRAC_BITS;
    fbt_r    = (ACW'(pf_r_r) + FB_HALF) >>> FB_FRAC_BITS;
    feed_l   = sat(ACW'(x_l) + fbt_l);
    feed_r   = sat(ACW'(x_r) + fbt_r);
    centre   = sat(ACW'(x_l) + ACW'(x_r) + fbt_c);
    lcr_mix  = stereo && (cfg.mode == MODE_LCR);
    pw_c_sel = lcr_mix ? pw_c_r : '0;
    wdata_c  = centre;
    if (!stereo) begin
      wdata_l = feed_l;
      wdata_r = feed_r;
    end else begin
      case (cfg.mode)
        MODE_PING_PONG: begin
          wdata_l = feed_r;
          wdata_r = feed_l;
        end
        MODE_LCR: begin
          wdata_l = x_l;
          wdata_r = x_r;
        end
        default: begin
          wdata_l = feed_l;
          wdata_r = feed_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      acc_l_r <= ACW'(pd_l_r) + ACW'(pw_l_r) + ACW'(pw_c_sel) + MIX_HALF;
      acc_r_r <= ACW'(pd_r_r) + ACW'(pw_r_r) + ACW'(pw_c_sel) + MIX_HALF;
      tap_l_r <= '0;
      tap_r_r <= '0;
    end else if (ctl.tap_acc) begin
      tap_l_r <= tap_l_r + TW'(y_l);
      tap_r_r <= tap_r_r + TW'(y_r);
    end
  end

  always_comb begin
    sum_l = (acc_l_r >>> GAIN_FRAC_BITS) + ACW'(tap_l_r);
    sum_r = (acc_r_r >>> GAIN_FRAC_BITS) + ACW'(tap_r_r);
    res_l = sat(sum_l);
    res_r = stereo ? sat(sum_r) : '0;
  end

endmodule
`default_nettype wire

// ===== rtl/stereo_multimode_delay_core.sv =====
// top level: config registers, request buffer, sequencer, delay line memories
// order: request buffer, S_MUL, S_WRITE, then S_TAP0 to S_TAPEND in tap delay
//   mode, S_FIN loads the output; the buffer takes a new request while one is in
//   process (tap mode reads three more samples on each line's single read port)
// reset: after rst_n, with in_tready low, the three lines are zeroed one entry
//   per cycle, all 2**LINE_AW of them; config writes are taken meanwhile
`timescale 1ns / 1ps
`default_nettype none
module stereo_multimode_delay_core #(
  parameter int unsigned LINE_AW        = smd_pkg::LINE_AW_DEF,
  parameter int unsigned SAMPLE_BITS    = smd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = smd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  // in_left, in_right
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,
  // right_present, stereo_out
  input  wire logic [1:0]                              in_tuser,
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  // out_left, out_right
  output logic      [((2*SAMPLE_BITS+7)/8)*8-1:0]      out_tdata,
  input  wire logic                                    cfg_we,
  input  wire logic [smd_pkg::CFG_ADDR_W-1:0]          cfg_addr,
  input  wire logic [smd_pkg::CFG_DATA_W-1:0]          cfg_data
);
  import smd_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned OUT_W = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int unsigned PW    = (LINE_AW > DELAY_W + 1) ? LINE_AW : DELAY_W + 1;

  function automatic logic [LINE_AW-1:0] back_addr(input logic [LINE_AW-1:0] base,
                                                   input logic [DELAY_W:0]   back);
    logic [PW-1:0] diff;
    diff = PW'(base) - PW'(back);
    return diff[LINE_AW-1:0];
  endfunction

  smd_cfg_t cfg_r, cfg_nxt;
  state_t   state_r, state_nxt;
  smd_ctl_t ctl;

  logic [LINE_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [LINE_AW-1:0] wp_r, wp_nxt;

  logic                 buf_valid_r, buf_valid_nxt;
  logic signed [SB-1:0] buf_l_r, buf_r_r;
  logic                 buf_present_r, buf_stereo_r;
  logic signed [SB-1:0] x_l_r, x_r_r;
  logic                 stereo_r;

  logic          out_valid_r, out_valid_nxt;
  logic [SB-1:0] out_l_r, out_r_r;
  logic          out_ok, tap_mode;

  logic [LINE_AW-1:0] base_w, raddr_l, raddr_c, raddr_r, waddr;
  logic [DELAY_W-1:0] toff_l, toff_r;
  logic [DELAY_W+1:0] d3_l, d3_r;
  logic               re_lr, we_l, we_c, we_r;
  logic [SB-1:0]      wd_l, wd_c, wd_r, dp_wl, dp_wc, dp_wr;
  logic [SB-1:0]      y_l, y_c, y_r, res_l, res_r;

  // configuration
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:          cfg_nxt.mode          = mode_t'(cfg_data[1:0]);
        REG_DELAY_LEFT:    cfg_nxt.delay_left    = cfg_data[DELAY_W-1:0];
        REG_DELAY_CENTRE:  cfg_nxt.delay_centre  = cfg_data[DELAY_W-1:0];
        REG_DELAY_RIGHT:   cfg_nxt.delay_right   = cfg_data[DELAY_W-1:0];
        REG_FEEDBACK_GAIN: cfg_nxt.feedback_gain = cfg_data[FB_GAIN_W-1:0];
        REG_DRY_GAIN:      cfg_nxt.dry_gain      = cfg_data[MIX_GAIN_W-1:0];
        REG_WET_GAIN:      cfg_nxt.wet_gain      = cfg_data[MIX_GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign out_ok   = !out_valid_r || out_tready;
  assign tap_mode = stereo_r && (cfg_r.mode == MODE_TAP);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_cnt_r == '1) state_nxt = S_IDLE;
      S_IDLE:   if (buf_valid_r) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_WRITE;
      S_WRITE:  state_nxt = tap_mode ? S_TAP0 : S_FIN;
      S_TAP0:   state_nxt = S_TAP1;
      S_TAP1:   state_nxt = S_TAP2;
      S_TAP2:   state_nxt = S_TAPEND;
      S_TAPEND: state_nxt = S_FIN;
      S_FIN: begin
        if (out_ok) begin
          state_nxt = buf_valid_r ? S_MUL : S_IDLE;
        end
      end
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      S_CLEAR: ctl.clearing = 1'b1;
      S_IDLE:  ctl.start    = buf_valid_r;
      S_MUL:   ctl.mul_en   = 1'b1;
      S_WRITE: ctl.wr_en    = 1'b1;
      S_TAP0: begin
        ctl.tap_rd  = 1'b1;
        ctl.tap_sel = TAP_3Q;
      end
      S_TAP1: begin
        ctl.tap_rd  = 1'b1;
        ctl.tap_sel = TAP_HALF;
        ctl.tap_acc = 1'b1;
      end
      S_TAP2: begin
        ctl.tap_rd  = 1'b1;
        ctl.tap_sel = TAP_1Q;
        ctl.tap_acc = 1'b1;
      end
      S_TAPEND: ctl.tap_acc = 1'b1;
      S_FIN: begin
        ctl.out_load = out_ok;
        ctl.start    = out_ok && buf_valid_r;
      end
      default: ;
    endcase
  end

  // request buffer and output register
  assign in_tready = !buf_valid_r && (state_r != S_CLEAR);

  always_comb begin
    buf_valid_nxt = buf_valid_r;
    if (in_tvalid && in_tready) begin
      buf_valid_nxt = 1'b1;
    end else if (ctl.start) begin
      buf_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    clr_cnt_nxt = ctl.clearing ? LINE_AW'(clr_cnt_r + 1'b1) : clr_cnt_r;
    wp_nxt      = ctl.out_load ? LINE_AW'(wp_r + 1'b1) : wp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      wp_r        <= '0;
      buf_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r.mode          <= MODE_NORMAL;
      cfg_r.delay_left    <= '0;
      cfg_r.delay_centre  <= '0;
      cfg_r.delay_right   <= '0;
      cfg_r.feedback_gain <= '0;
      cfg_r.dry_gain      <= MIX_GAIN_RST;
      cfg_r.wet_gain      <= MIX_GAIN_RST;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      wp_r        <= wp_nxt;
      buf_valid_r <= buf_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      buf_l_r       <= in_tdata[SB-1:0];
      buf_r_r       <= in_tdata[2*SB-1:SB];
      buf_present_r <= in_tuser[0];
      buf_stereo_r  <= in_tuser[1];
    end
    if (ctl.start) begin
      x_l_r    <= buf_l_r;
      x_r_r    <= buf_present_r ? buf_r_r : buf_l_r;
      stereo_r <= buf_stereo_r;
    end
    if (ctl.out_load) begin
      out_l_r <= res_l;
      out_r_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_r_r, out_l_r});

  // line addressing
  always_comb begin
    d3_l = ((DELAY_W+2)'(cfg_r.delay_left) * (DELAY_W+2)'(3)) >> 2;
    d3_r = ((DELAY_W+2)'(cfg_r.delay_right) * (DELAY_W+2)'(3)) >> 2;
    case (ctl.tap_sel)
      TAP_3Q: begin
        toff_l = d3_l[DELAY_W-1:0];
        toff_r = d3_r[DELAY_W-1:0];
      end
      TAP_HALF: begin
        toff_l = cfg_r.delay_left >> 1;
        toff_r = cfg_r.delay_right >> 1;
      end
      default: begin
        toff_l = cfg_r.delay_left >> 2;
        toff_r = cfg_r.delay_right >> 2;
      end
    endcase
    base_w = (state_r == S_FIN) ? LINE_AW'(wp_r + 1'b1) : wp_r;
    if (ctl.start) begin
      raddr_l = back_addr(base_w, {1'b0, cfg_r.delay_left} + 1'b1);
      raddr_r = back_addr(base_w, {1'b0, cfg_r.delay_right} + 1'b1);
    end else begin
      raddr_l = back_addr(wp_r, {1'b0, toff_l});
      raddr_r = back_addr(wp_r, {1'b0, toff_r});
    end
    raddr_c = back_addr(base_w, {1'b0, cfg_r.delay_centre} + 1'b1);
    re_lr   = ctl.start || ctl.tap_rd;
    waddr   = ctl.clearing ? clr_cnt_r : wp_r;
    we_l    = ctl.clearing || ctl.wr_en;
    we_r    = ctl.clearing || (ctl.wr_en && stereo_r);
    we_c    = ctl.clearing || (ctl.wr_en && stereo_r && (cfg_r.mode == MODE_LCR));
    wd_l    = ctl.clearing ? '0 : dp_wl;
    wd_c    = ctl.clearing ? '0 : dp_wc;
    wd_r    = ctl.clearing ? '0 : dp_wr;
  end

  smd_line_ram #(.AW(LINE_AW), .DW(SB)) u_line_l (
    .clk   (clk),
    .we    (we_l),
    .waddr (waddr),
    .wdata (wd_l),
    .re    (re_lr),
    .raddr (raddr_l),
    .rdata (y_l)
  );

  smd_line_ram #(.AW(LINE_AW), .DW(SB)) u_line_c (
    .clk   (clk),
    .we    (we_c),
    .waddr (waddr),
    .wdata (wd_c),
    .re    (ctl.start),
    .raddr (raddr_c),
    .rdata (y_c)
  );

  smd_line_ram #(.AW(LINE_AW), .DW(SB)) u_line_r (
    .clk   (clk),
    .we    (we_r),
    .waddr (waddr),
    .wdata (wd_r),
    .re    (re_lr),
    .raddr (raddr_r),
    .rdata (y_r)
  );

  smd_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .cfg     (cfg_r),
    .ctl     (ctl),
    .x_l     (x_l_r),
    .x_r     (x_r_r),
    .stereo  (stereo_r),
    .y_l     (y_l),
    .y_c     (y_c),
    .y_r     (y_r),
    .wdata_l (dp_wl),
    .wdata_c (dp_wc),
    .wdata_r (dp_wr),
    .res_l   (res_l),
    .res_r   (res_r)
  );

endmodule
`default_nettype wire

// ===== rtl/smd_checker.sv =====
// port level checks for the stereo multimode delay, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module smd_checker #(
  parameter int unsigned SAMPLE_BITS = smd_pkg::SAMPLE_BITS_DEF
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] out_tdata
);

  // requests taken but not yet delivered
  logic [2:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = 3'(pend_r + 1'b1);
    end else if (!in_acc && out_acc) begin
      pend_nxt = 3'(pend_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ports not quiet after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 3'd0)
    else $error("result without a request");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd3)
    else $error("more requests in flight than storage");

endmodule

bind stereo_multimode_delay_core smd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_smd_checker (.*);
`default_nettype wire
